@@ design/mmagc_pkg.sv @@
package mmagc_pkg;

  localparam int unsigned LEVEL_BITS = 8;
  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = 8'hFF;
  localparam int unsigned DIV_STEPS = 4;
  localparam int unsigned CNT_W = $clog2(DIV_STEPS);

  localparam logic KIND_GATHER = 1'b0;
  localparam logic KIND_MAP = 1'b1;

  typedef struct packed {
    logic        kind;
    logic        first_of_frame;
    logic [15:0] pixel;
  } in_t;

  typedef struct packed {
    logic [7:0] level;
    logic       flat_frame;
  } out_t;

  typedef struct packed {
    logic gather;
    logic map_start;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic bypass;
    logic out_free;
  } sts_t;

endpackage

@@ design/mmagc_ctrl.sv @@
module mmagc_ctrl
  import mmagc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_kind,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid & in_ready;

  always_comb begin
    cmd.gather    = accept & (in_kind == KIND_GATHER);
    cmd.map_start = accept & (in_kind == KIND_MAP);
    cmd.div_step  = (state_r == ST_DIV);
    cmd.load_out  = (state_r == ST_HOLD) & sts.out_free;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (cmd.map_start) begin
          state_nxt = sts.bypass ? ST_HOLD : ST_DIV;
        end
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

@@ design/mmagc_dp.sv @@
module mmagc_dp
  import mmagc_pkg::*;
#(
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  in_t  in_data,
  input  cmd_t cmd,
  output sts_t sts,
  input  logic out_ready,
  output logic out_valid,
  output out_t out_data
);

  localparam int unsigned NUM_W = PIXEL_BITS + LEVEL_BITS;

  logic [PIXEL_BITS-1:0] lo_r, lo_nxt;
  logic [PIXEL_BITS-1:0] hi_r, hi_nxt;
  logic [PIXEL_BITS-1:0] span_r, rem_r, rem_nxt;
  logic [LEVEL_BITS-1:0] num_r, num_nxt;
  logic [LEVEL_BITS-1:0] quo_r, quo_nxt;
  logic                  flat_r;
  logic                  out_valid_r;
  out_t                  out_data_r;

  logic [PIXEL_BITS-1:0] p;
  logic [PIXEL_BITS-1:0] diff;
  logic [NUM_W-1:0]      num_full;
  logic                  flat;
  logic                  below;
  logic                  above;
  logic [PIXEL_BITS:0]   trial_a, trial_b;
  logic [PIXEL_BITS-1:0] rem_a, rem_b;
  logic                  bit_a, bit_b;

  assign p        = in_data.pixel[PIXEL_BITS-1:0];
  assign flat     = (hi_r <= lo_r);
  assign below    = (p <= lo_r);
  assign above    = (p >= hi_r);
  assign diff     = p - lo_r;
  assign num_full = {diff, {LEVEL_BITS{1'b0}}} - NUM_W'(diff);

  assign sts.bypass   = flat | below | above;
  assign sts.out_free = ~out_valid_r | out_ready;

  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    if (cmd.gather) begin
      if (in_data.first_of_frame) begin
        lo_nxt = p;
        hi_nxt = p;
      end else begin
        if (p < lo_r) begin
          lo_nxt = p;
        end
        if (p > hi_r) begin
          hi_nxt = p;
        end
      end
    end
  end

  always_comb begin
    trial_a = {rem_r, num_r[LEVEL_BITS-1]};
    bit_a   = (trial_a >= {1'b0, span_r});
    rem_a   = bit_a ? PIXEL_BITS'(trial_a - {1'b0, span_r}) : trial_a[PIXEL_BITS-1:0];
    trial_b = {rem_a, num_r[LEVEL_BITS-2]};
    bit_b   = (trial_b >= {1'b0, span_r});
    rem_b   = bit_b ? PIXEL_BITS'(trial_b - {1'b0, span_r}) : trial_b[PIXEL_BITS-1:0];
  end

  always_comb begin
    rem_nxt = rem_r;
    num_nxt = num_r;
    quo_nxt = quo_r;
    if (cmd.map_start) begin
      rem_nxt = num_full[NUM_W-1:LEVEL_BITS];
      num_nxt = num_full[LEVEL_BITS-1:0];
      quo_nxt = (flat | below) ? '0 : LEVEL_MAX;
    end else if (cmd.div_step) begin
      rem_nxt = rem_b;
      num_nxt = {num_r[LEVEL_BITS-3:0], 2'b00};
      quo_nxt = {quo_r[LEVEL_BITS-3:0], bit_a, bit_b};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r        <= '1;
      hi_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    if (cmd.map_start) begin
      span_r <= hi_r - lo_r;
      flat_r <= flat;
    end
    if (cmd.load_out) begin
      out_data_r.level      <= quo_r;
      out_data_r.flat_frame <= flat_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ design/min_max_linear_agc_16to8_core.sv @@
// Channel  Ports                          Carries
// in       in_valid, in_ready, in_data    gather or map request with one pixel
// out      out_valid, out_ready, out_data stretched level and flat-frame flag
//
// A gather request updates the running minimum and maximum and gives no result.
// A map request is taken while idle and forms 255*(p-min); the divider then
// retires two quotient bits per step, and the output register is loaded when free.
// Saturated and flat pixels skip the divider and go straight to the output load.
// Reset sets the minimum to all ones and the maximum to zero.
// A stalled result holds in the output register while the next request is taken.
module min_max_linear_agc_16to8_core
  import mmagc_pkg::*;
#(
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  cmd_t cmd;
  sts_t sts;

  mmagc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_data.kind),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mmagc_dp #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

@@ sim/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mmagc_pkg::*;

  localparam int unsigned PIX_BITS = 16;
  localparam logic [15:0] PIX_MASK = 16'((32'd1 << PIX_BITS) - 32'd1);
  localparam int unsigned RANDOM_REQUESTS = 800;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct {
    in_t  req;
    bit   fixed;
    out_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  logic [15:0] stat_min = PIX_MASK;
  logic [15:0] stat_max = '0;
  out_t        level_q[$];
  row_t        directed[$];
  bit          cur_fixed;
  out_t        cur_want;
  bit          hold_req;
  bit          free_run;
  int unsigned errors;
  int unsigned idle_cycles;

  min_max_linear_agc_16to8_core #(
    .PIXEL_BITS(PIX_BITS)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic in_t make_req(logic kind, logic first, logic [15:0] px);
    in_t r;
    r.kind = kind;
    r.first_of_frame = first;
    r.pixel = px;
    return r;
  endfunction

  function automatic out_t stretch_pixel(logic [15:0] px_in);
    out_t        r;
    int unsigned lo;
    int unsigned hi;
    int unsigned px;
    int unsigned q;
    lo = 32'(stat_min);
    hi = 32'(stat_max);
    px = 32'(px_in & PIX_MASK);
    r.flat_frame = (hi <= lo);
    r.level = '0;
    if (!r.flat_frame) begin
      if (px >= hi) begin
        r.level = LEVEL_MAX;
      end else if (px > lo) begin
        q = (32'(LEVEL_MAX) * (px - lo)) / (hi - lo);
        r.level = q[7:0];
      end
    end
    return r;
  endfunction

  task automatic note_error(string what, out_t want, out_t got);
    errors++;
    if (errors <= REPORT_LIMIT) begin
      $display("mismatch (%s): expected level %0d flat %0b, got level %0d flat %0b",
               what, want.level, want.flat_frame, got.level, got.flat_frame);
    end
  endtask

  always @(posedge clk) begin : monitor
    out_t   want;
    logic [15:0] px;
    bit     moved;
    if (!rst_n) begin
      stat_min = PIX_MASK;
      stat_max = '0;
      idle_cycles = 0;
    end else begin
      moved = 1'b0;
      if (out_valid && out_ready) begin
        moved = 1'b1;
        if (level_q.size() == 0) begin
          note_error("no request pending", '0, out_data);
        end else begin
          want = level_q.pop_front();
          if (out_data.level !== want.level || out_data.flat_frame !== want.flat_frame) begin
            note_error("field", want, out_data);
          end
        end
      end
      if (in_valid && in_ready) begin
        moved = 1'b1;
        px = in_data.pixel & PIX_MASK;
        if (in_data.kind == KIND_GATHER) begin
          if (in_data.first_of_frame) begin
            stat_min = px;
            stat_max = px;
          end else begin
            if (px < stat_min) stat_min = px;
            if (px > stat_max) stat_max = px;
          end
        end else begin
          level_q.push_back(cur_fixed ? cur_want : stretch_pixel(px));
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("** min_max_linear_agc_16to8_core: FAILED **");
        $finish;
      end
    end
  end

  initial begin : result_sink
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= free_run || ($urandom_range(99) >= 29);
      end
    end
  end

  task automatic send_request(input in_t r, input bit fixed, input out_t want);
    while (!free_run && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    cur_fixed = fixed;
    cur_want = want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic add_row(logic kind, logic first, logic [15:0] px, bit fixed,
                         logic [7:0] lvl, logic flat);
    row_t r;
    r.req = make_req(kind, first, px);
    r.fixed = fixed;
    r.want.level = lvl;
    r.want.flat_frame = flat;
    directed.push_back(r);
  endtask

  initial begin : stimulus
    int unsigned sent;
    int unsigned frame;
    int unsigned n_gather;
    int unsigned n_map;
    int unsigned lo_b;
    int unsigned hi_b;
    int unsigned a;
    int unsigned b;
    int unsigned pick;
    logic [15:0] px;
    bit          broken;
    out_t        none;

    in_valid = 1'b0;
    in_data = '0;
    rst_n = 1'b0;
    hold_req = 1'b0;
    free_run = 1'b0;
    errors = 0;
    none = '0;

    // A map request before any gather sees an empty range and reads as flat.
    add_row(KIND_MAP,    1'b0, 16'h1234, 1, 8'd0, 1'b1);
    add_row(KIND_MAP,    1'b1, 16'hFFFF, 1, 8'd0, 1'b1);
    add_row(KIND_GATHER, 1'b1, 16'h1000, 0, 8'd0, 1'b0);
    add_row(KIND_MAP,    1'b0, 16'h1000, 1, 8'd0, 1'b1);
    add_row(KIND_MAP,    1'b0, 16'h0000, 1, 8'd0, 1'b1);
    add_row(KIND_GATHER, 1'b1, 16'h0000, 0, 8'd0, 1'b0);
    add_row(KIND_GATHER, 1'b0, 16'hFFFF, 0, 8'd0, 1'b0);
    add_row(KIND_MAP,    1'b0, 16'h0000, 1, 8'd0, 1'b0);
    add_row(KIND_MAP,    1'b0, 16'hFFFF, 1, LEVEL_MAX, 1'b0);
    add_row(KIND_MAP,    1'b0, 16'h8000, 0, 8'd0, 1'b0);
    add_row(KIND_MAP,    1'b1, 16'h5555, 0, 8'd0, 1'b0);
    add_row(KIND_MAP,    1'b0, 16'hAAAA, 0, 8'd0, 1'b0);
    add_row(KIND_GATHER, 1'b1, 16'h2000, 0, 8'd0, 1'b0);
    add_row(KIND_GATHER, 1'b0, 16'h3000, 0, 8'd0, 1'b0);
    add_row(KIND_GATHER, 1'b0, 16'h2800, 0, 8'd0, 1'b0);
    add_row(KIND_MAP,    1'b0, 16'h1000, 1, 8'd0, 1'b0);
    add_row(KIND_MAP,    1'b0, 16'h4000, 1, LEVEL_MAX, 1'b0);
    add_row(KIND_MAP,    1'b0, 16'h2000, 1, 8'd0, 1'b0);
    add_row(KIND_MAP,    1'b0, 16'h3000, 1, LEVEL_MAX, 1'b0);
    add_row(KIND_MAP,    1'b0, 16'h2001, 0, 8'd0, 1'b0);
    add_row(KIND_MAP,    1'b0, 16'h2FFF, 0, 8'd0, 1'b0);
    add_row(KIND_GATHER, 1'b1, 16'hFFFF, 0, 8'd0, 1'b0);
    add_row(KIND_MAP,    1'b0, 16'hFFFF, 1, 8'd0, 1'b1);
    add_row(KIND_GATHER, 1'b0, 16'hFFFE, 0, 8'd0, 1'b0);
    add_row(KIND_MAP,    1'b0, 16'hFFFE, 1, 8'd0, 1'b0);
    add_row(KIND_MAP,    1'b1, 16'hFFFF, 1, LEVEL_MAX, 1'b0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_request(directed[i].req, directed[i].fixed, directed[i].want);

    sent = 0;
    frame = 0;
    while (sent < RANDOM_REQUESTS) begin
      frame++;
      free_run = (frame >= 30 && frame < 45);
      if (frame == 20) begin
        in_valid <= 1'b0;
        do @(negedge clk); while (level_q.size() != 0);
      end

      case ($urandom_range(3))
        0: begin
          lo_b = $urandom_range(65535 - 15, 0);
          hi_b = lo_b + $urandom_range(15, 0);
        end
        1: begin
          lo_b = $urandom_range(60000, 0);
          hi_b = lo_b + $urandom_range(5535, 16);
        end
        2: begin
          lo_b = $urandom_range(255, 0);
          hi_b = $urandom_range(65535, 65280);
        end
        default: begin
          a = $urandom_range(65535, 0);
          b = $urandom_range(65535, 0);
          lo_b = (a < b) ? a : b;
          hi_b = (a < b) ? b : a;
        end
      endcase

      // Now and then a frame runs on from the previous statistics or skips gathering.
      broken = ($urandom_range(9) == 0);
      n_gather = (broken && $urandom_range(1) == 1) ? 0 : $urandom_range(12, 1);
      for (int unsigned i = 0; i < n_gather; i++) begin
        px = 16'($urandom_range(hi_b, lo_b));
        send_request(make_req(KIND_GATHER, (i == 0) ? !broken : ($urandom_range(19) == 0),
                              px), 0, none);
        sent++;
      end

      n_map = (frame == 10) ? 40 : $urandom_range(16, 1);
      if (frame == 10) hold_req = 1'b1;
      for (int unsigned j = 0; j < n_map; j++) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          px = 16'($urandom_range(hi_b, lo_b));
        end else if (pick < 85) begin
          px = 16'($urandom);
        end else begin
          case ($urandom_range(5))
            0: px = 16'h0000;
            1: px = 16'hFFFF;
            2: px = 16'(lo_b);
            3: px = 16'(hi_b);
            4: px = 16'(lo_b - 1);
            default: px = 16'(hi_b + 1);
          endcase
        end
        send_request(make_req(KIND_MAP, 1'($urandom_range(1)), px), 0, none);
        sent++;
      end
    end

    in_valid <= 1'b0;
    free_run = 1'b0;
    while (level_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (errors == 0) begin
      $display("** min_max_linear_agc_16to8_core: PASSED **");
    end else begin
      $display("** min_max_linear_agc_16to8_core: FAILED **");
    end
    $finish;
  end

endmodule
